// ===== rtl/core/fcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpm_pkg
// Shared types and constants of the flagged character pattern matcher.
// ----------------------------------------------------------------------------
package fcpm_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CUR_W       = 6;
    localparam int LEN_W       = 6;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_FEED    = 2'd2;

    localparam int F_ALL    = 0;
    localparam int F_EXACT  = 1;
    localparam int F_INVERT = 2;
    localparam int F_KO     = 3;
    localparam int F_TERM   = 4;
    localparam int F_NOCAP  = 5;
    localparam int F_CONS   = 6;
    localparam int F_NOOP   = 7;
    localparam int F_ANY    = 8;
    localparam int F_MANY   = 9;
    localparam int F_OPT    = 10;

    typedef struct packed {
        logic [10:0] flags;
        logic [7:0]  lo;
        logic [7:0]  hi;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  entry_index;
        logic [10:0] entry_flags;
        logic [7:0]  range_low;
        logic [7:0]  range_high;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic        miss_flag;
        logic        processing_flag;
        logic        knockout_flag;
        logic        term_found_flag;
        logic        complete_flag;
        logic [15:0] kept_count;
        logic [15:0] lead_count;
        logic [15:0] tail_count;
        logic [5:0]  cursor_position;
    } out_item_t;

endpackage

// ===== rtl/core/fcpm_if.sv =====
// ----------------------------------------------------------------------------
// fcpm_in_if / fcpm_out_if
// Valid/ready channels of the matcher.
// ----------------------------------------------------------------------------
interface fcpm_in_if;
    import fcpm_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcpm_out_if;
    import fcpm_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/flagged_char_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// flagged_char_pattern_matcher
// Byte-at-a-time matcher over a loaded table of flagged character classes.
// ----------------------------------------------------------------------------
// channel   dir  content
// in_ch     in   load entry / restart / data byte
// out_ch    out  flags, counts and cursor after each item
// cfg       in   pattern_length write
//
// Load and restart pass straight to the done state. A data byte reads table
// entries from the table memory one at a time, walking forward to the next
// term entry or backward to the start of the term run.
// Reset clears the state and flags; the table stays undefined until loaded.
// A waiting result holds the output register; the next item is taken only
// after the result leaves.
// ----------------------------------------------------------------------------
module flagged_char_pattern_matcher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [5:0]            cfg_wdata,
    fcpm_in_if.sink               in_ch,
    fcpm_out_if.source            out_ch
);
    import fcpm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_EVAL  = 7'b0000100,
        ST_FRD   = 7'b0001000,
        ST_FWD   = 7'b0010000,
        ST_BWD   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic rd_en;

    logic [LEN_W-1:0]       len_reg;
    logic [CUR_W-1:0]       cur_reg, cur_next;
    logic [COUNT_WIDTH-1:0] cap_reg, cap_next, lead_reg, lead_next, tail_reg, tail_next;
    logic miss_reg, miss_next, proc_reg, proc_next, ko_reg, ko_next;
    logic termf_reg, termf_next, cmpl_reg, cmpl_next;
    logic [7:0] byte_reg;
    logic out_valid_reg;

    logic [CUR_W-1:0] end_w;
    assign end_w = (len_reg > CUR_W'(TABLE_DEPTH)) ? CUR_W'(TABLE_DEPTH) : CUR_W'(len_reg);

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    logic m;
    always_comb
    begin
        if (rd_reg.flags[F_ALL])
            m = 1'b1;
        else if (rd_reg.flags[F_EXACT])
            m = (byte_reg == rd_reg.lo);
        else
            m = (byte_reg >= rd_reg.lo) && (byte_reg <= rd_reg.hi);
        m = m ^ rd_reg.flags[F_INVERT];
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.data.kind == KIND_LOAD
            && 32'(in_ch.data.entry_index) < TABLE_DEPTH)
            mem[IDX_W'(in_ch.data.entry_index)] <= {in_ch.data.entry_flags,
                in_ch.data.range_low, in_ch.data.range_high};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    logic accept;
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg; cap_next = cap_reg; lead_next = lead_reg; tail_next = tail_reg;
        miss_next = miss_reg; proc_next = proc_reg; ko_next = ko_reg;
        termf_next = termf_reg; cmpl_next = cmpl_reg;
        rd_en = 1'b0;
        rd_addr = cur_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    if (in_ch.data.kind == KIND_RESTART)
                    begin
                        cur_next = '0; cap_next = '0; lead_next = '0; tail_next = '0;
                        miss_next = 1'b0; proc_next = 1'b0; ko_next = 1'b0;
                        termf_next = 1'b0; cmpl_next = 1'b0;
                    end
                    else if (in_ch.data.kind == KIND_FEED && !miss_reg)
                    begin
                        if (cur_reg < end_w)
                        begin
                            rd_en = 1'b1;
                            state_next = ST_EVAL;
                        end
                        else if (cur_reg == end_w)
                        begin
                            cmpl_next = 1'b1; proc_next = 1'b0;
                        end
                    end
                end
            end
            ST_RD:
            begin
                rd_en = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_DONE;
                if (m)
                begin
                    if (rd_reg.flags[F_KO])
                    begin
                        if (!rd_reg.flags[F_NOCAP] || rd_reg.flags[F_CONS])
                            tail_next = bump(tail_reg);
                        if (rd_reg.flags[F_NOOP] || cap_reg == '0)
                        begin
                            miss_next = 1'b1;
                            cur_next = '0;
                        end
                        else
                        begin
                            proc_next = 1'b0; ko_next = 1'b1;
                            state_next = ST_FWD;
                        end
                    end
                    else
                    begin
                        proc_next = 1'b1;
                        if (rd_reg.flags[F_NOCAP])
                        begin
                            if (cap_reg == '0)
                                lead_next = bump(lead_reg);
                            else if (cur_reg + 1'b1 == end_w)
                                tail_next = bump(tail_reg);
                            else
                                cap_next = bump(cap_reg);
                        end
                        else
                            cap_next = bump(cap_reg);
                        if (rd_reg.flags[F_ANY] || rd_reg.flags[F_MANY])
                        begin
                            termf_next = 1'b1;
                            state_next = ST_BWD;
                        end
                        else
                        begin
                            termf_next = 1'b0;
                            state_next = ST_FWD;
                        end
                    end
                end
                else if (rd_reg.flags[F_KO] || rd_reg.flags[F_OPT] ||
                         ((rd_reg.flags[F_MANY] || rd_reg.flags[F_ANY]) &&
                          !(rd_reg.flags[F_TERM] && !termf_reg)))
                begin
                    cur_next = cur_reg + 1'b1;
                    if (cur_reg + 1'b1 < end_w)
                        state_next = ST_RD;
                    else
                    begin
                        cmpl_next = 1'b1; proc_next = 1'b0;
                    end
                end
                else
                begin
                    proc_next = 1'b0; cur_next = '0; cap_next = '0; lead_next = '0;
                end
                if (state_next == ST_FWD || state_next == ST_BWD)
                    state_next = state_t'(state_next);
            end
            ST_FWD:
            begin
                if (rd_reg.flags[F_TERM])
                begin
                    cur_next = cur_reg + 1'b1;
                    state_next = ST_DONE;
                    if (cur_reg + 1'b1 == end_w)
                    begin
                        cmpl_next = 1'b1; proc_next = 1'b0;
                    end
                end
                else if (cur_reg + 1'b1 < end_w)
                begin
                    cur_next = cur_reg + 1'b1;
                    rd_addr = cur_next[IDX_W-1:0];
                    rd_en = 1'b1;
                    state_next = ST_FRD;
                end
                else
                begin
                    cur_next = end_w;
                    cmpl_next = 1'b1; proc_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_FRD:
            begin
                state_next = ST_FWD;
            end
            ST_BWD:
            begin
                if (cur_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    rd_addr = IDX_W'(cur_reg - 1'b1);
                    rd_en = 1'b1;
                    state_next = ST_DONE;
                    if (rd_en && state_reg == ST_BWD)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // backward scan: check the entry read last cycle, step until term flag
    logic bwd_chk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bwd_chk_reg <= 1'b0;
            len_reg <= LEN_W'(1);
            cur_reg <= '0; cap_reg <= '0; lead_reg <= '0; tail_reg <= '0;
            miss_reg <= 1'b0; proc_reg <= 1'b0; ko_reg <= 1'b0;
            termf_reg <= 1'b0; cmpl_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_wdata;
            cap_reg <= cap_next; lead_reg <= lead_next; tail_reg <= tail_next;
            miss_reg <= miss_next; proc_reg <= proc_next; ko_reg <= ko_next;
            termf_reg <= termf_next; cmpl_reg <= cmpl_next;
            if (state_reg == ST_BWD && cur_reg != '0)
            begin
                if (bwd_chk_reg && rd_reg.flags[F_TERM])
                begin
                    bwd_chk_reg <= 1'b0;
                    state_reg <= ST_DONE;
                    cur_reg <= cur_reg;
                end
                else
                begin
                    if (bwd_chk_reg)
                        cur_reg <= cur_reg - 1'b1;
                    else
                        cur_reg <= cur_reg;
                    bwd_chk_reg <= !bwd_chk_reg;
                    state_reg <= ST_BWD;
                end
            end
            else
            begin
                bwd_chk_reg <= 1'b0;
                state_reg <= state_next;
                cur_reg <= cur_next;
            end
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= in_ch.data.data_byte;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = '{miss_flag: miss_reg, processing_flag: proc_reg,
        knockout_flag: ko_reg, term_found_flag: termf_reg, complete_flag: cmpl_reg,
        kept_count: cap_reg, lead_count: lead_reg, tail_count: tail_reg,
        cursor_position: cur_reg};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready) else $error("busy accept");
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (cur_reg < end_w)) else $error("cursor range");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid_reg) else $error("lost result");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flagged character pattern matcher. A scoreboard
// class keeps its own copy of the table, cursor, counts and flags, predicts
// the status result of every accepted item and compares each result, field by
// field, in order. Stimulus loads the table, restarts and feeds bytes that
// mostly follow the entry under the predicted cursor, over several lengths.
// ----------------------------------------------------------------------------
module tb_top;
    import fcpm_pkg::*;

    class match_scoreboard;
        entry_t      slots [TABLE_DEPTH];
        int unsigned plen;
        int unsigned cur;
        int unsigned kept, lead, tail;
        bit          miss, proc_f, ko_f, termf, done_f;
        out_item_t   status_q [$];
        int          errors;
        int          n_results;

        function new();
            foreach (slots[i]) slots[i] = '0;
            plen = 1;
            errors = 0;
            n_results = 0;
            clear_state();
        endfunction

        function void clear_state();
            cur = 0; kept = 0; lead = 0; tail = 0;
            miss = 0; proc_f = 0; ko_f = 0; termf = 0; done_f = 0;
        endfunction

        function void set_length(logic [5:0] v);
            plen = v;
        endfunction

        function int unsigned active_len();
            return (plen > TABLE_DEPTH) ? TABLE_DEPTH : plen;
        endfunction

        function bit term_at(int unsigned i);
            return (i < TABLE_DEPTH) ? slots[i].flags[F_TERM] : 1'b0;
        endfunction

        function void bump(ref int unsigned c);
            if (c < COUNT_MAX) c++;
        endfunction

        function bit class_hit(logic [7:0] c, entry_t e);
            bit m;
            if (e.flags[F_ALL]) m = 1;
            else if (e.flags[F_EXACT]) m = (c == e.lo);
            else m = (c >= e.lo) && (c <= e.hi);
            if (e.flags[F_INVERT]) m = !m;
            return m;
        endfunction

        function void skip_to_next_term(int unsigned lim);
            while (cur < lim && !term_at(cur)) cur++;
            if (cur < lim && term_at(cur)) cur++;
        endfunction

        function void back_to_term_start();
            while (cur > 0 && !term_at(cur - 1)) cur--;
        endfunction

        function void drop_match();
            proc_f = 0; cur = 0; kept = 0; lead = 0;
        endfunction

        function void feed_byte(logic [7:0] c);
            int unsigned lim;
            entry_t      e;
            logic [10:0] f;
            lim = active_len();
            if (miss) return;
            while (cur < lim) begin
                e = slots[cur];
                f = e.flags;
                if (class_hit(c, e)) begin
                    if (f[F_KO]) begin
                        if (!f[F_NOCAP] || f[F_CONS]) bump(tail);
                        if (f[F_NOOP] || kept == 0) begin
                            miss = 1;
                            cur = 0;
                            return;
                        end
                        proc_f = 0;
                        ko_f = 1;
                        skip_to_next_term(lim);
                        break;
                    end
                    proc_f = 1;
                    if (f[F_NOCAP]) begin
                        if (kept == 0) bump(lead);
                        else if (cur + 1 == lim) bump(tail);
                        else bump(kept);
                    end
                    else bump(kept);
                    if (f[F_ANY] || f[F_MANY]) begin
                        back_to_term_start();
                        termf = 1;
                    end
                    else begin
                        skip_to_next_term(lim);
                        termf = 0;
                    end
                    break;
                end
                if (f[F_KO] || f[F_OPT]) cur++;
                else if (f[F_MANY] || f[F_ANY]) begin
                    if (f[F_TERM] && !termf) begin
                        drop_match();
                        break;
                    end
                    cur++;
                end
                else begin
                    drop_match();
                    break;
                end
            end
            if (cur == lim) begin
                done_f = 1;
                proc_f = 0;
            end
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            if (it.kind == KIND_LOAD)
                slots[it.entry_index] = '{it.entry_flags, it.range_low, it.range_high};
            else if (it.kind == KIND_RESTART)
                clear_state();
            else if (it.kind == KIND_FEED)
                feed_byte(it.data_byte);
            r.miss_flag       = miss;
            r.processing_flag = proc_f;
            r.knockout_flag   = ko_f;
            r.term_found_flag = termf;
            r.complete_flag   = done_f;
            r.kept_count      = kept[15:0];
            r.lead_count      = lead[15:0];
            r.tail_count      = tail[15:0];
            r.cursor_position = cur[5:0];
            status_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            n_results++;
            if (status_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = status_q.pop_front();
            if (got.miss_flag !== want.miss_flag) report("miss_flag", want.miss_flag, got.miss_flag);
            if (got.processing_flag !== want.processing_flag)
                report("processing_flag", want.processing_flag, got.processing_flag);
            if (got.knockout_flag !== want.knockout_flag)
                report("knockout_flag", want.knockout_flag, got.knockout_flag);
            if (got.term_found_flag !== want.term_found_flag)
                report("term_found_flag", want.term_found_flag, got.term_found_flag);
            if (got.complete_flag !== want.complete_flag)
                report("complete_flag", want.complete_flag, got.complete_flag);
            if (got.kept_count !== want.kept_count) report("kept_count", want.kept_count, got.kept_count);
            if (got.lead_count !== want.lead_count) report("lead_count", want.lead_count, got.lead_count);
            if (got.tail_count !== want.tail_count) report("tail_count", want.tail_count, got.tail_count);
            if (got.cursor_position !== want.cursor_position)
                report("cursor_position", want.cursor_position, got.cursor_position);
        endfunction

        function void report(string name, logic [15:0] want, logic [15:0] got);
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [5:0] cfg_wdata = '0;

    fcpm_in_if  in_ch ();
    fcpm_out_if out_ch ();

    flagged_char_pattern_matcher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    match_scoreboard sb = new();
    bit  idle_on = 1'b1;
    int  long_hold_req = 0;
    int  stall_left = 0;
    int  n_items = 0;
    int  n_feeds = 0;
    int  n_phases = 0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            if (long_hold_req > 0)
            begin
                stall_left = long_hold_req;
                long_hold_req = 0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(in_item_t it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_item(it);
        n_items++;
        if (it.kind == KIND_FEED) n_feeds++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.status_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_length(logic [5:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_length(v);
        @(posedge clk);
        n_phases++;
    endtask

    function automatic in_item_t noise_item(logic [1:0] k);
        in_item_t    it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.kind = k;
        return it;
    endfunction

    function automatic in_item_t load_item(int idx, logic [10:0] f, logic [7:0] lo, logic [7:0] hi);
        in_item_t it;
        it = noise_item(KIND_LOAD);
        it.entry_index = 5'(idx);
        it.entry_flags = f;
        it.range_low = lo;
        it.range_high = hi;
        return it;
    endfunction

    function automatic in_item_t feed_item(logic [7:0] c);
        in_item_t it;
        it = noise_item(KIND_FEED);
        it.data_byte = c;
        return it;
    endfunction

    function automatic logic [10:0] random_flags();
        logic [10:0] f;
        if ($urandom_range(0, 9) == 0) return 11'($urandom);
        f = '0;
        case ($urandom_range(0, 3))
            0: f[F_EXACT] = 1'b1;
            1: f[F_ALL] = 1'b1;
            default: ;
        endcase
        f[F_TERM]   = ($urandom_range(0, 1) == 0);
        f[F_OPT]    = ($urandom_range(0, 4) == 0);
        f[F_MANY]   = ($urandom_range(0, 6) == 0);
        f[F_ANY]    = ($urandom_range(0, 9) == 0);
        f[F_NOCAP]  = ($urandom_range(0, 5) == 0);
        f[F_KO]     = ($urandom_range(0, 9) == 0);
        f[F_INVERT] = ($urandom_range(0, 9) == 0);
        f[F_NOOP]   = ($urandom_range(0, 9) == 0);
        f[F_CONS]   = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    task automatic load_random(int idx);
        logic [7:0] lo;
        lo = 8'($urandom);
        send_item(load_item(idx, random_flags(), lo, lo + 8'($urandom_range(0, 40))));
    endtask

    function automatic logic [7:0] steered_byte();
        entry_t e;
        if (sb.cur >= TABLE_DEPTH || $urandom_range(0, 9) < 3) return 8'($urandom);
        e = sb.slots[sb.cur];
        if (e.flags[F_EXACT] && !e.flags[F_ALL]) return e.lo;
        if (e.hi >= e.lo) return 8'($urandom_range(e.lo, e.hi));
        return 8'($urandom);
    endfunction

    initial
    begin
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_length(6'd32);
        for (k = 0; k < TABLE_DEPTH; k++) load_random(k);

        write_length(6'd3);
        send_item(load_item(0, 11'h012, 8'h41, 8'h00));
        send_item(load_item(1, 11'h600, 8'h30, 8'h39));
        send_item(load_item(2, 11'h07D, 8'h00, 8'hFF));
        send_item(noise_item(KIND_RESTART));
        send_item(feed_item(8'h41));
        send_item(feed_item(8'h35));
        send_item(feed_item(8'h36));
        send_item(feed_item(8'h00));
        send_item(feed_item(8'hFF));
        send_item(noise_item(2'd3));
        send_item(load_item(0, 11'h008, 8'h00, 8'hFF));
        send_item(noise_item(KIND_RESTART));
        send_item(feed_item(8'h20));
        send_item(feed_item(8'h21));
        send_item(noise_item(KIND_RESTART));
        send_item(load_item(31, 11'h7FF, 8'hFF, 8'h00));
        send_item(load_item(0, 11'h414, 8'h80, 8'h7F));
        send_item(feed_item(8'h7F));
        send_item(feed_item(8'h80));

        write_length(6'd1);
        send_item(feed_item(8'h55));

        while (n_items < 1150)
        begin
            case (n_phases % 5)
                0: write_length(6'd32);
                1: write_length(6'd1);
                default: write_length(6'($urandom_range(1, 32)));
            endcase
            if (n_items > 1000) idle_on = 1'b0;
            repeat ($urandom_range(1, 6)) load_random($urandom_range(0, TABLE_DEPTH - 1));
            send_item(noise_item(KIND_RESTART));
            if (n_phases == 4)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
                long_hold_req = 500;
            end
            repeat (60)
            begin
                k = $urandom_range(0, 39);
                if (k == 0) send_item(noise_item(2'd3));
                else if (k == 1) load_random($urandom_range(0, TABLE_DEPTH - 1));
                else if (k < 4 || (sb.miss && k < 12) || (sb.done_f && k < 8))
                    send_item(noise_item(KIND_RESTART));
                else send_item(feed_item(steered_byte()));
            end
        end

        drain();
        $display("covered %0d items (%0d bytes fed) over %0d length settings", n_items, n_feeds,
                 n_phases);
        $display("checked %0d results, %0d mismatches", sb.n_results, sb.errors);
        if (sb.errors == 0 && sb.status_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
